// ===== rtl/prr_pkg.sv =====
`timescale 1ns / 1ps

package prr_pkg;

    // defaults for the top level parameters
    localparam int NUM_SENDERS_DEF = 16;
    localparam int WINDOW_DEF      = 16;

    // most deliveries one transaction may release
    localparam int MAX_RESULTS = 16;

    // field widths
    localparam int SENDER_W  = 4;
    localparam int SEQ_W     = 32;
    localparam int CONTENT_W = 32;
    localparam int ACTIVE_W  = 5;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    // result status codes
    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_STALE     = 2'd1,
        ST_BEYOND    = 2'd2,
        ST_INACTIVE  = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PARK,
        S_REL_RD,
        S_REL
    } t_state;

    typedef struct packed {
        logic [SENDER_W-1:0]  sender_index;
        logic [SEQ_W-1:0]     seq_number;
        logic [CONTENT_W-1:0] content;
    } t_in_item;

    typedef struct packed {
        logic [SENDER_W-1:0]  out_sender;
        logic [SEQ_W-1:0]     out_seq;
        logic [CONTENT_W-1:0] out_content;
        t_status              status;
        logic                 last;
    } t_result;

    // one parked slot
    typedef struct packed {
        logic                 valid;
        logic [CONTENT_W-1:0] content;
    } t_slot;

endpackage

// ===== rtl/prr_slot_mem.sv =====
`timescale 1ns / 1ps

module prr_slot_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output prr_pkg::t_slot                o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic                          i_wr_valid,
    input  logic                          i_wr_content_en,
    input  logic [prr_pkg::CONTENT_W-1:0] i_wr_content
);
    import prr_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    // field-wise write, the content field keeps its value when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr].valid <= i_wr_valid;
            if (i_wr_content_en) begin
                r_mem[i_wr_addr].content <= i_wr_content;
            end
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/prr_exp_mem.sv =====
`timescale 1ns / 1ps

module prr_exp_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // expected sequence number and its slot pointer per sender
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/prr_ctrl.sv =====
`timescale 1ns / 1ps

module prr_ctrl #(
    parameter int NUM_SENDERS = prr_pkg::NUM_SENDERS_DEF,
    parameter int WINDOW      = prr_pkg::WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  prr_pkg::t_in_item            i_item,
    input  logic [prr_pkg::ACTIVE_W-1:0] i_active_senders,
    output logic                         o_strobe,
    output prr_pkg::t_result             o_result
);
    import prr_pkg::*;

    localparam int SA        = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
    localparam int PW        = $clog2(WINDOW);
    localparam int NUM_SLOTS = NUM_SENDERS * WINDOW;
    localparam int AW        = $clog2(NUM_SLOTS);
    localparam int EW        = SEQ_W + PW;
    localparam int NW        = $clog2(MAX_RESULTS + 1);

    localparam logic [EW-1:0] EXP_INIT = {32'd1, PW'(1)};

    t_state              r_state, n_state;
    t_in_item            r_item, n_item;
    logic [SA-1:0]       r_addr, n_addr;
    logic [SEQ_W-1:0]    r_exp, n_exp;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_slot, n_slot;
    logic [AW-1:0]       r_clr, n_clr;
    logic [NW-1:0]       r_cnt, n_cnt;
    t_result             r_pend, n_pend;
    logic                r_pend_v, n_pend_v;
    logic                r_same, n_same;
    t_result             r_out, n_out;
    logic                r_strobe, n_strobe;

    logic                exp_rd_en;
    logic [SA-1:0]       exp_rd_addr;
    logic [EW-1:0]       exp_rd_data;
    logic                exp_wr_en;
    logic [SA-1:0]       exp_wr_addr;
    logic [EW-1:0]       exp_wr_data;

    logic                slot_rd_en;
    logic [AW-1:0]       slot_rd_addr;
    t_slot               slot_rd_data;
    logic                slot_wr_en;
    logic [AW-1:0]       slot_wr_addr;
    logic                slot_wr_valid;
    logic                slot_wr_content_en;

    logic                w_accept;
    logic                w_inactive;
    logic [SEQ_W-1:0]    w_rd_seq;
    logic [PW-1:0]       w_rd_ptr;
    logic [SEQ_W-1:0]    w_diff;
    logic                w_stale;
    logic                w_beyond;
    logic [PW:0]         w_sum;
    logic [PW-1:0]       w_off;
    logic [AW-1:0]       w_base;
    logic [AW-1:0]       w_slot_chk;
    logic [AW-1:0]       w_cur;
    logic [PW-1:0]       w_nxt_ptr;
    logic [AW-1:0]       w_nxt_slot;
    logic                w_avail;
    logic                w_clr_done;

    // memories
    prr_exp_mem #(
        .DEPTH (NUM_SENDERS),
        .AW    (SA),
        .DW    (EW)
    ) u_exp_mem (
        .i_clk     (i_clk),
        .i_rd_en   (exp_rd_en),
        .i_rd_addr (exp_rd_addr),
        .o_rd_data (exp_rd_data),
        .i_wr_en   (exp_wr_en),
        .i_wr_addr (exp_wr_addr),
        .i_wr_data (exp_wr_data)
    );

    prr_slot_mem #(
        .DEPTH (NUM_SLOTS),
        .AW    (AW)
    ) u_slot_mem (
        .i_clk           (i_clk),
        .i_rd_en         (slot_rd_en),
        .i_rd_addr       (slot_rd_addr),
        .o_rd_data       (slot_rd_data),
        .i_wr_en         (slot_wr_en),
        .i_wr_addr       (slot_wr_addr),
        .i_wr_valid      (slot_wr_valid),
        .i_wr_content_en (slot_wr_content_en),
        .i_wr_content    (r_item.content)
    );

    // datapath helpers
    always_comb begin
        w_accept   = i_start && (r_state == S_IDLE);
        w_inactive = ({1'b0, i_item.sender_index} >= i_active_senders)
                     || (32'(i_item.sender_index) >= 32'(NUM_SENDERS));
        w_rd_seq   = exp_rd_data[EW-1:PW];
        w_rd_ptr   = exp_rd_data[PW-1:0];
        w_diff     = r_item.seq_number - w_rd_seq;
        w_stale    = r_item.seq_number < w_rd_seq;
        w_beyond   = w_diff >= 32'(WINDOW);
        w_sum      = {1'b0, w_rd_ptr} + {1'b0, w_diff[PW-1:0]};
        if (w_sum >= (PW+1)'(WINDOW)) begin
            w_off = PW'(w_sum - (PW+1)'(WINDOW));
        end else begin
            w_off = w_sum[PW-1:0];
        end
        w_base     = AW'(r_addr) * AW'(WINDOW);
        w_slot_chk = w_base + AW'(w_off);
        w_cur      = w_base + AW'(r_ptr);
        // the pointer restarts at zero at the end of the window and when the sequence counter wraps
        if ((r_exp == '1) || (r_ptr == PW'(WINDOW - 1))) begin
            w_nxt_ptr = '0;
        end else begin
            w_nxt_ptr = r_ptr + 1'b1;
        end
        w_nxt_slot = w_base + AW'(w_nxt_ptr);
        // slot just cleared at the same address reads as empty
        w_avail    = slot_rd_data.valid && !r_same;
        w_clr_done = (r_clr == AW'(NUM_SLOTS - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (w_clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start && !w_inactive) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_stale || w_beyond) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PARK;
                end
            end
            S_PARK: begin
                if (slot_rd_data.valid) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_REL_RD;
                end
            end
            S_REL_RD: begin
                n_state = S_REL;
            end
            S_REL: begin
                if (!(w_avail && (32'(r_cnt) < MAX_RESULTS))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // outputs and datapath registers
    always_comb begin
        n_item             = r_item;
        n_addr             = r_addr;
        n_exp              = r_exp;
        n_ptr              = r_ptr;
        n_slot             = r_slot;
        n_clr              = r_clr;
        n_cnt              = r_cnt;
        n_pend             = r_pend;
        n_pend_v           = r_pend_v;
        n_same             = r_same;
        n_out              = r_out;
        n_strobe           = 1'b0;
        exp_rd_en          = 1'b0;
        exp_rd_addr        = r_addr;
        exp_wr_en          = 1'b0;
        exp_wr_addr        = r_addr;
        exp_wr_data        = {r_exp, r_ptr};
        slot_rd_en         = 1'b0;
        slot_rd_addr       = w_cur;
        slot_wr_en         = 1'b0;
        slot_wr_addr       = w_cur;
        slot_wr_valid      = 1'b0;
        slot_wr_content_en = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                // sweep after reset: empty every slot, reset expected numbers
                slot_wr_en   = 1'b1;
                slot_wr_addr = r_clr;
                if (32'(r_clr) < 32'(NUM_SENDERS)) begin
                    exp_wr_en   = 1'b1;
                    exp_wr_addr = r_clr[SA-1:0];
                    exp_wr_data = EXP_INIT;
                end
                n_clr = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_item = i_item;
                    n_addr = SA'(i_item.sender_index);
                    if (w_inactive) begin
                        n_strobe = 1'b1;
                        n_out    = '{out_sender:  i_item.sender_index,
                                     out_seq:     i_item.seq_number,
                                     out_content: '0,
                                     status:      ST_INACTIVE,
                                     last:        1'b1};
                    end else begin
                        exp_rd_en   = 1'b1;
                        exp_rd_addr = SA'(i_item.sender_index);
                    end
                end
            end
            S_CHECK: begin
                n_exp = w_rd_seq;
                n_ptr = w_rd_ptr;
                if (w_stale || w_beyond) begin
                    n_strobe = 1'b1;
                    n_out    = '{out_sender:  r_item.sender_index,
                                 out_seq:     r_item.seq_number,
                                 out_content: '0,
                                 status:      w_stale ? ST_STALE : ST_BEYOND,
                                 last:        1'b1};
                end else begin
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = w_slot_chk;
                    n_slot       = w_slot_chk;
                end
            end
            S_PARK: begin
                if (slot_rd_data.valid) begin
                    // duplicate: parked content stays
                    n_strobe = 1'b1;
                    n_out    = '{out_sender:  r_item.sender_index,
                                 out_seq:     r_item.seq_number,
                                 out_content: '0,
                                 status:      ST_STALE,
                                 last:        1'b1};
                end else begin
                    slot_wr_en         = 1'b1;
                    slot_wr_addr       = r_slot;
                    slot_wr_valid      = 1'b1;
                    slot_wr_content_en = 1'b1;
                    n_cnt              = '0;
                    n_pend_v           = 1'b0;
                end
            end
            S_REL_RD: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = w_cur;
                n_same       = 1'b0;
            end
            S_REL: begin
                if (w_avail && (32'(r_cnt) < MAX_RESULTS)) begin
                    // release this slot, held back in the pending register to know last
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_out    = r_pend;
                    end
                    n_pend       = '{out_sender:  r_item.sender_index,
                                     out_seq:     r_exp,
                                     out_content: slot_rd_data.content,
                                     status:      ST_DELIVERED,
                                     last:        1'b0};
                    n_pend_v     = 1'b1;
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = w_cur;
                    n_exp        = r_exp + 1'b1;
                    n_ptr        = w_nxt_ptr;
                    n_cnt        = r_cnt + 1'b1;
                    n_same       = (w_nxt_ptr == r_ptr);
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = w_nxt_slot;
                end else begin
                    // end of run: flush the held result and store progress
                    if (r_pend_v) begin
                        n_strobe      = 1'b1;
                        n_out         = r_pend;
                        n_out.last    = 1'b1;
                    end
                    n_pend_v  = 1'b0;
                    exp_wr_en = 1'b1;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
            r_same   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
            r_pend_v <= n_pend_v;
            r_same   <= n_same;
            r_cnt    <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_addr <= n_addr;
        r_exp  <= n_exp;
        r_ptr  <= n_ptr;
        r_slot <= n_slot;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ===== rtl/per_sender_reorder_release.sv =====
// timing: drops come from the idle (inactive sender), check (stale, beyond-window)
// and park (duplicate) states; a release passes the park and release-read states and
// waits in a pending register; a parked transaction keeps the block busy for its run
// of up to 16 released results, each taking one read-modify-write of the slot memory;
// reset: synchronous, then a clearing pass over all NUM_SENDERS * WINDOW slots (256
// by default) with busy high; results carry a strobe and cannot be stalled
`timescale 1ns / 1ps

module per_sender_reorder_release #(
    parameter int NUM_SENDERS = prr_pkg::NUM_SENDERS_DEF,
    parameter int WINDOW      = prr_pkg::WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  prr_pkg::t_in_item            i_item,
    input  logic                         i_cfg_we,
    input  logic [prr_pkg::ACTIVE_W-1:0] i_cfg_wdata,
    output logic                         o_strobe,
    output prr_pkg::t_result             o_result
);
    import prr_pkg::*;

    logic [ACTIVE_W-1:0] r_active_senders;

    // active sender count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_senders <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active_senders <= i_cfg_wdata;
        end
    end

    prr_ctrl #(
        .NUM_SENDERS (NUM_SENDERS),
        .WINDOW      (WINDOW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_item           (i_item),
        .i_active_senders (r_active_senders),
        .o_strobe         (o_strobe),
        .o_result         (o_result)
    );

endmodule

// ===== rtl/prr_checker.sv =====
`timescale 1ns / 1ps

module prr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input prr_pkg::t_in_item            i_item,
    input logic                         i_cfg_we,
    input logic [prr_pkg::ACTIVE_W-1:0] i_cfg_wdata,
    input logic                         o_strobe,
    input prr_pkg::t_result             o_result
);
    import prr_pkg::*;

    // reset starts the clearing pass
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // a drop is always the only and final result of its transaction
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_DELIVERED)) |-> o_result.last)
        else $error("drop result without last");

    // a drop carries no content
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_DELIVERED)) |-> (o_result.out_content == '0))
        else $error("drop result with content");

    // a released run comes out in consecutive cycles
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap inside a released run");

    // an accepted transaction either drops at once or keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || (o_strobe && o_result.last)))
        else $error("transaction accepted without effect");

endmodule

bind per_sender_reorder_release prr_checker u_prr_checker (.*);

// ===== dv/per_sender_reorder_release_tb.sv =====
`timescale 1ns / 1ps

module per_sender_reorder_release_tb;
    import prr_pkg::*;

    localparam int NSEND       = NUM_SENDERS_DEF;
    localparam int WIN         = WINDOW_DEF;
    localparam int SETTLE_CYC  = 24;
    localparam int TAIL_CYC    = 40;

    // kinds of queued stimulus commands
    typedef enum logic [1:0] {
        CMD_MSG,
        CMD_CFG,
        CMD_DRAIN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        t_in_item            item;
        logic [ACTIVE_W-1:0] cfg;
        logic                steady;
    } t_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_in_item            i_item = '0;
    logic                i_cfg_we = 1'b0;
    logic [ACTIVE_W-1:0] i_cfg_wdata = '0;
    logic                o_strobe;
    t_result             o_result;

    // stimulus and expected outcomes
    t_cmd        cmd_q[$];
    t_result     outcome_q[$];
    int          err_cnt = 0;
    logic        took = 1'b0;
    int          gap_cnt = 0;
    int          settle_cnt = 0;
    logic        cur_steady = 1'b0;

    // predictor state: per-sender next sequence and parked window slots
    logic [SEQ_W-1:0]     next_seq[NSEND];
    logic                 park_valid[NSEND*WIN];
    logic [CONTENT_W-1:0] park_data[NSEND*WIN];
    logic [ACTIVE_W-1:0]  sender_limit = ACTIVE_RESET;

    // stimulus planning: next sequence number to hand out per sender
    logic [SEQ_W-1:0]     plan_next[NSEND];

    per_sender_reorder_release dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // reset once at the start
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // predictor state after reset
    initial begin
        for (int i = 0; i < NSEND; i++) begin
            next_seq[i]  = 32'd1;
            plan_next[i] = 32'd1;
        end
        for (int i = 0; i < NSEND * WIN; i++) begin
            park_valid[i] = 1'b0;
            park_data[i]  = '0;
        end
    end

    // park one transaction and work out the drop or the released run
    task automatic predict_outcome(input t_in_item it);
        t_result          r;
        logic [SEQ_W-1:0] exp_n;
        logic [SEQ_W-1:0] seq_gap;
        int               base;
        int               sl;
        int               n;
        r = '0;
        r.out_sender = it.sender_index;
        r.out_seq    = it.seq_number;
        r.last       = 1'b1;
        exp_n   = next_seq[it.sender_index];
        seq_gap = it.seq_number - exp_n;
        base    = int'(it.sender_index) * WIN;
        sl      = base + int'(it.seq_number % 32'(WIN));
        if (ACTIVE_W'(it.sender_index) >= sender_limit || int'(it.sender_index) >= NSEND) begin
            r.status = ST_INACTIVE;
            outcome_q = {outcome_q, r};
        end else if (it.seq_number < exp_n) begin
            r.status = ST_STALE;
            outcome_q = {outcome_q, r};
        end else if (seq_gap >= 32'(WIN)) begin
            r.status = ST_BEYOND;
            outcome_q = {outcome_q, r};
        end else if (park_valid[sl]) begin
            // duplicate keeps the parked content
            r.status = ST_STALE;
            outcome_q = {outcome_q, r};
        end else begin
            park_valid[sl] = 1'b1;
            park_data[sl]  = it.content;
            n = 0;
            while (n < MAX_RESULTS && park_valid[base + int'(exp_n % 32'(WIN))]) begin
                sl = base + int'(exp_n % 32'(WIN));
                r.out_seq     = exp_n;
                r.out_content = park_data[sl];
                r.status      = ST_DELIVERED;
                r.last        = 1'b0;
                outcome_q = {outcome_q, r};
                park_valid[sl] = 1'b0;
                exp_n = exp_n + 32'd1;
                n++;
            end
            next_seq[it.sender_index] = exp_n;
            if (n > 0)
                outcome_q[outcome_q.size() - 1].last = 1'b1;
        end
    endtask

    // stimulus command helpers
    function automatic void add_msg(input int snd, input logic [SEQ_W-1:0] seq,
                                    input logic [CONTENT_W-1:0] data, input logic steady);
        t_cmd c;
        c = '0;
        c.kind = CMD_MSG;
        c.item.sender_index = SENDER_W'(snd);
        c.item.seq_number   = seq;
        c.item.content      = data;
        c.steady = steady;
        cmd_q = {cmd_q, c};
    endfunction

    function automatic void add_cfg(input logic [ACTIVE_W-1:0] val);
        t_cmd c;
        c = '0;
        c.kind = CMD_CFG;
        c.cfg  = val;
        cmd_q = {cmd_q, c};
    endfunction

    function automatic void add_drain();
        t_cmd c;
        c = '0;
        c.kind = CMD_DRAIN;
        cmd_q = {cmd_q, c};
    endfunction

    // mostly shuffled in-window runs per sender, plus stale, beyond and random noise
    function automatic void add_traffic(input int count, input int senders,
                                        input logic steady);
        int               made;
        int               pick;
        int               k;
        int               s;
        int               j;
        logic [SEQ_W-1:0] order[16];
        logic [SEQ_W-1:0] tmp;
        made = 0;
        while (made < count) begin
            s    = $urandom_range(0, senders - 1);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                add_msg($urandom_range(0, 15), $urandom, $urandom, steady);
                made++;
            end else if (pick == 1) begin
                add_msg(s, $urandom_range(0, plan_next[s] - 1), $urandom, steady);
                made++;
            end else if (pick == 2) begin
                add_msg(s, plan_next[s] + 32'(WIN) + $urandom_range(0, 3), $urandom, steady);
                made++;
            end else begin
                k = ($urandom_range(0, 9) == 0) ? WIN : $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                    order[i] = plan_next[s] + 32'(i);
                for (int i = k - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < k; i++)
                    add_msg(s, order[i], $urandom, steady);
                plan_next[s] = plan_next[s] + 32'(k);
                made += k;
            end
        end
    endfunction

    // driver: one transaction or register write at a time, with random gaps outside steady traffic
    always @(negedge i_clk) begin
        logic                go;
        t_in_item            nxt;
        logic                we;
        logic [ACTIVE_W-1:0] wd;
        go  = start;
        nxt = i_item;
        we  = 1'b0;
        wd  = i_cfg_wdata;
        if (i_rst_n) begin
            if (start && took) begin
                go = 1'b0;
                if (!cur_steady && $urandom_range(0, 2) == 0)
                    gap_cnt = $urandom_range(1, 4);
            end
            if (!go) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (cmd_q.size() > 0) begin
                    case (cmd_q[0].kind)
                        CMD_MSG: begin
                            go         = 1'b1;
                            nxt        = cmd_q[0].item;
                            cur_steady = cmd_q[0].steady;
                            void'(cmd_q.pop_front());
                        end
                        default: begin
                            // wait for all outcomes and a quiet block
                            if (outcome_q.size() == 0 && busy === 1'b0)
                                settle_cnt++;
                            else
                                settle_cnt = 0;
                            if (settle_cnt >= SETTLE_CYC) begin
                                settle_cnt = 0;
                                if (cmd_q[0].kind == CMD_CFG) begin
                                    we = 1'b1;
                                    wd = cmd_q[0].cfg;
                                end
                                void'(cmd_q.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        start       <= go;
        i_item      <= nxt;
        i_cfg_we    <= we;
        i_cfg_wdata <= wd;
    end

    // monitor: check results, track register writes and accepted transactions
    always @(posedge i_clk) begin
        t_result want;
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (outcome_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: expected none actual %0d/%0d/%h/%0d/%0b",
                             $time, o_result.out_sender, o_result.out_seq,
                             o_result.out_content, o_result.status, o_result.last);
                end else begin
                    want = outcome_q.pop_front();
                    if (o_result.out_sender !== want.out_sender ||
                        o_result.out_seq !== want.out_seq ||
                        o_result.out_content !== want.out_content ||
                        o_result.status !== want.status ||
                        o_result.last !== want.last) begin
                        err_cnt++;
                        $display("%0t: expected %0d/%0d/%h/%0d/%0b actual %0d/%0d/%h/%0d/%0b",
                                 $time, want.out_sender, want.out_seq, want.out_content,
                                 want.status, want.last, o_result.out_sender,
                                 o_result.out_seq, o_result.out_content,
                                 o_result.status, o_result.last);
                    end
                end
            end
            if (i_cfg_we)
                sender_limit = i_cfg_wdata;
            if (start && !busy)
                predict_outcome(i_item);
        end
    end

    // stimulus plan and end of run
    initial begin
        // directed: stale, duplicate and beyond-window drops, window edges and a full-window release
        add_cfg(5'd31);
        add_msg(0, 32'd1, 32'hFFFF_FFFF, 1'b0);
        add_msg(0, 32'd0, 32'h0000_0000, 1'b0);
        add_msg(0, 32'd1, 32'h1234_5678, 1'b0);
        add_msg(15, 32'd3, 32'h0000_0000, 1'b0);
        add_msg(15, 32'd3, 32'hA5A5_A5A5, 1'b0);
        add_msg(15, 32'd17, 32'h5A5A_5A5A, 1'b0);
        add_msg(15, 32'd16, 32'hDEAD_BEEF, 1'b0);
        add_msg(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_msg(15, 32'd2, $urandom, 1'b0);
        for (int i = 4; i < 16; i++)
            add_msg(15, 32'(i), $urandom, 1'b0);
        add_msg(15, 32'd1, 32'hCAFE_F00D, 1'b0);
        plan_next[0]  = 32'd2;
        plan_next[15] = 32'd17;

        // no sender active
        add_cfg(5'd0);
        add_msg(0, 32'd2, $urandom, 1'b0);
        add_msg(15, 32'd17, $urandom, 1'b0);

        // only sender zero active
        add_cfg(5'd1);
        add_msg(0, 32'd2, $urandom, 1'b0);
        add_msg(1, 32'd1, $urandom, 1'b0);
        add_msg(0, 32'd2, $urandom, 1'b0);
        plan_next[0] = 32'd3;

        // random traffic under several limits
        add_cfg(5'd16);
        add_traffic(45, NSEND, 1'b0);
        add_drain();
        add_traffic(15, NSEND, 1'b0);
        add_cfg(5'd7);
        add_traffic(35, 7, 1'b0);
        add_cfg(5'd31);
        add_traffic(30, NSEND, 1'b0);
        add_traffic(25, NSEND, 1'b1);

        @(posedge i_rst_n);
        while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_cnt == 0 && outcome_q.size() == 0)
            $display("per_sender_reorder_release_tb passed");
        else
            $display("per_sender_reorder_release_tb failed");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("per_sender_reorder_release_tb failed");
        $finish;
    end

endmodule
